FILE: design/crc32fc_pkg.sv
// Shared types, constants and CRC helper functions for the CRC-32 frame checker.
package crc32fc_pkg;

    typedef logic [31:0] crc_t;
    typedef crc_t        nib_tbl_t [16];

    localparam crc_t       CRC_POLY  = 32'h741B8CD7;
    localparam crc_t       CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [2:0] MIN_FRAME = 3'd5;
    localparam logic [2:0] TRAILER_LEN = 3'd4;

    // One result of a finished frame
    typedef struct packed {
        logic frame_too_short;
        logic crc_match;
        crc_t received_crc;
        crc_t computed_crc;
    } result_t;

    // Build the nibble table: each top nibble shifted four times through the polynomial
    function automatic nib_tbl_t make_nib_tbl();
        nib_tbl_t tbl;
        crc_t     v;
        for (int n = 0; n < 16; n++)
        begin
            v = crc_t'(n) << 28;
            for (int k = 0; k < 4; k++)
            begin
                v = v[31] ? ((v << 1) ^ CRC_POLY) : (v << 1);
            end
            tbl[n] = v;
        end
        return tbl;
    endfunction

    localparam nib_tbl_t NIB_TBL = make_nib_tbl();

    // Fold one byte into the low bits, then shift all 32 bits out in eight nibble rounds
    function automatic crc_t crc_byte(crc_t crc, logic [7:0] b);
        crc_t v;
        v = crc ^ {24'd0, b};
        for (int r = 0; r < 8; r++)
        begin
            v = (v << 4) ^ NIB_TBL[v[31:28]];
        end
        return v;
    endfunction

endpackage

FILE: design/crc32_frame_checker.sv
// Top level of the CRC-32 frame checker: byte stream in, one result per frame out.
// Results: a frame's result enters the result buffer when its last byte is accepted.
// Throughput: one byte per cycle while the result buffer has room; the CRC byte step
// is an eight-round nibble-table XOR network between the frame state registers, and
// a two-entry result buffer lets bytes keep flowing while a result waits.
// Reset: mode resets to 1 (trailer check); CRC to all ones, window and count to zero.
module crc32_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // [0] check_mode
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // end_of_frame
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // [31:0] computed_crc, [63:32] received_crc
    output logic [1:0]  m_tuser        // [0] crc_match, [1] frame_too_short
);
    import crc32fc_pkg::*;

    logic       check_mode_reg;
    crc_t       crc_reg;
    crc_t       crc_next;
    logic [7:0] win_reg [4];
    logic [7:0] win_next [4];
    logic [2:0] seen_reg;
    logic [2:0] seen_next;

    logic       accept;
    logic       advance;
    logic [7:0] crc_in;
    crc_t       crc_upd;
    logic [2:0] seen_upd;
    crc_t       rx_crc;
    result_t    res;
    logic       buf_not_full;
    result_t    buf_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = buf_not_full;
    assign accept    = s_tvalid && s_tready;

    // Feed the byte straight in for mode 0, the oldest window byte once four are held in mode 1
    assign advance  = !check_mode_reg || (seen_reg >= TRAILER_LEN);
    assign crc_in   = check_mode_reg ? win_reg[0] : s_tdata;
    assign crc_upd  = advance ? crc_byte(crc_reg, crc_in) : crc_reg;
    assign seen_upd = (seen_reg < MIN_FRAME) ? (seen_reg + 3'd1) : seen_reg;
    assign rx_crc   = (seen_upd >= TRAILER_LEN) ?
                      {win_reg[1], win_reg[2], win_reg[3], s_tdata} : 32'd0;

    // Form the frame result
    always_comb
    begin
        res = '0;
        if (!check_mode_reg)
        begin
            res.computed_crc = crc_upd;
        end
        else
        begin
            res.received_crc = rx_crc;
            if (seen_upd >= MIN_FRAME)
            begin
                res.computed_crc = crc_upd;
                res.crc_match    = (crc_upd == rx_crc);
            end
            else
            begin
                res.frame_too_short = 1'b1;
            end
        end
    end

    // Advance frame state, clear it after the last byte
    always_comb
    begin
        crc_next  = crc_reg;
        seen_next = seen_reg;
        for (int i = 0; i < 4; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (accept)
        begin
            if (s_tlast)
            begin
                crc_next  = CRC_INIT;
                seen_next = 3'd0;
                for (int i = 0; i < 4; i++)
                begin
                    win_next[i] = 8'd0;
                end
            end
            else
            begin
                crc_next    = crc_upd;
                seen_next   = seen_upd;
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = win_reg[3];
                win_next[3] = s_tdata;
            end
        end
    end

    // Hold mode and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_mode_reg <= 1'b1;
            crc_reg        <= CRC_INIT;
            seen_reg       <= 3'd0;
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                check_mode_reg <= cfg_data[0];
            end
            crc_reg  <= crc_next;
            seen_reg <= seen_next;
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Queue results toward the master side
    crc32fc_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && s_tlast),
        .push_data (res),
        .not_full  (buf_not_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_data)
    );

    assign m_tdata = {buf_data.received_crc, buf_data.computed_crc};
    assign m_tuser = {buf_data.frame_too_short, buf_data.crc_match};

endmodule

FILE: design/crc32fc_out_buf.sv
// Two-entry result buffer that decouples frame processing from the master side.
module crc32fc_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  crc32fc_pkg::result_t push_data,
    output logic                 not_full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output crc32fc_pkg::result_t out_data
);
    import crc32fc_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    head_reg;
    result_t    head_next;
    result_t    tail_reg;
    result_t    tail_next;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && out_ready;
    assign not_full  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;

    // Pick next head, tail and fill level
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = push_data;
                end
                else
                begin
                    tail_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Hold the fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold the entries
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
